// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the fan boost activation sequencer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a condition at every clock edge outside reset
`define FBAS_ASSERT(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("fbas assertion failed");

// check that a condition at one edge implies another at the next edge
`define FBAS_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("fbas assertion failed");

`endif

// ===== rtl/core/fbas_pkg.sv =====
// Types and constants of the fan boost activation sequencer
`default_nettype none
package fbas_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPINUP_COUNTDOWN = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_HOLD      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_SPEED        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_DISTANCE    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEER_THRESHOLD  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_STANDSTILL       = 3'd5;

   localparam logic [12:0] RESET_SPINUP_COUNTDOWN = 13'd5000;
   localparam logic [12:0] RESET_ACTIVE_HOLD      = 13'd1000;
   localparam logic [14:0] RESET_MIN_SPEED        = 15'd500;
   localparam logic [15:0] RESET_STOP_DISTANCE    = 16'd200;
   localparam logic [11:0] RESET_STEER_THRESHOLD  = 12'd0;
   localparam logic [7:0]  RESET_STANDSTILL       = 8'd90;

   // two's complement, -1000 ms
   localparam logic [13:0] TIMER_FLOOR_MS = 14'(-14'sd1000);

   typedef struct packed {
      logic [12:0] spinup_countdown_ms;
      logic [12:0] active_hold_ms;
      logic [14:0] min_speed_mm_s;
      logic [15:0] stop_distance_mm;
      logic [11:0] steer_threshold_mrad;
      logic [7:0]  standstill_cmd;
   } fbas_cfg_type;

   typedef struct packed {
      logic        sequence_started;
      logic        spinup_completed;
      logic        fan_permit;
      logic        hold_active;
      logic [13:0] spinup_timer_ms;
      logic [13:0] hold_timer_ms;
   } fbas_state_type;

   typedef struct packed {
      logic        engine_enable_in;
      logic [7:0]  fan_speed_cmd;
      logic [9:0]  loop_time_ms;
      logic [12:0] steering_mrad;
      logic        track_lines_valid;
      logic        vectors_valid;
      logic [15:0] obstacle_distance_mm;
      logic        finish_slowdown;
      logic [14:0] car_speed_mm_s;
   } fbas_req_type;

   typedef struct packed {
      logic       engine_enable_out;
      logic [7:0] fan_drive_cmd;
      logic       fan_active;
      logic       spinup_done;
   } fbas_rsp_type;

endpackage
`default_nettype wire

// ===== rtl/core/fbas_chan_if.sv =====
// Valid/ready channel interface carrying one payload word
`default_nettype none
interface fbas_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/fbas_step.sv =====
// Per-tick sequencer logic: next state and result word from one input word
`default_nettype none
module fbas_step (
   input  wire fbas_pkg::fbas_cfg_type   cfg,
   input  wire fbas_pkg::fbas_state_type state,
   input  wire fbas_pkg::fbas_req_type   req_word,
   output fbas_pkg::fbas_state_type      state_in,
   output fbas_pkg::fbas_rsp_type        rsp_word
);
   import fbas_pkg::*;

   function automatic logic [13:0] count_down(logic [13:0] t, logic [9:0] dt);
      logic signed [14:0] r;
      r = $signed({t[13], t}) - $signed({5'b0, dt});
      if (r < $signed({TIMER_FLOOR_MS[13], TIMER_FLOOR_MS})) begin
         return TIMER_FLOOR_MS;
      end
      return r[13:0];
   endfunction

   function automatic logic not_positive(logic [13:0] t);
      return t[13] || (t == '0);
   endfunction

   logic        eng;
   logic        started;
   logic        completed;
   logic        permit;
   logic        hold;
   logic [13:0] spin_t;
   logic [13:0] hold_t;
   logic [12:0] steer_mag;
   logic        req_above;
   logic        cond;

   always_comb begin
      eng       = req_word.engine_enable_in;
      started   = state.sequence_started;
      completed = state.spinup_completed;
      permit    = state.fan_permit;
      hold      = state.hold_active;
      spin_t    = state.spinup_timer_ms;
      hold_t    = state.hold_timer_ms;
      req_above = req_word.fan_speed_cmd > cfg.standstill_cmd;
      steer_mag = req_word.steering_mrad[12] ? (~req_word.steering_mrad + 13'd1)
                                             : req_word.steering_mrad;

      if (!eng && completed) begin
         permit  = 1'b1;
         started = 1'b0;
      end

      if (eng && !started) begin
         spin_t  = req_above ? {1'b0, cfg.spinup_countdown_ms} : '0;
         started = 1'b1;
      end

      completed = 1'b0;
      if (started) begin
         spin_t    = count_down(spin_t, req_word.loop_time_ms);
         completed = not_positive(spin_t);
         eng       = completed;
      end

      if (eng) begin
         if (!req_word.track_lines_valid || !req_word.vectors_valid
             || (req_word.obstacle_distance_mm <= cfg.stop_distance_mm)
             || req_word.finish_slowdown) begin
            permit = 1'b0;
         end
      end

      cond = started && (req_word.car_speed_mm_s >= cfg.min_speed_mm_s) && permit;
      if (cond) begin
         if (hold) begin
            hold_t = count_down(hold_t, req_word.loop_time_ms);
            if (not_positive(hold_t)) begin
               hold = 1'b0;
            end
         end
         if (steer_mag >= {1'b0, cfg.steer_threshold_mrad}) begin
            hold   = 1'b1;
            hold_t = {1'b0, cfg.active_hold_ms};
         end
      end else begin
         hold_t = '0;
         hold   = 1'b0;
      end

      state_in.sequence_started = started;
      state_in.spinup_completed = completed;
      state_in.fan_permit       = permit;
      state_in.hold_active      = hold;
      state_in.spinup_timer_ms  = spin_t;
      state_in.hold_timer_ms    = hold_t;

      rsp_word.engine_enable_out = eng;
      rsp_word.fan_drive_cmd     = (cond && req_above) ? req_word.fan_speed_cmd
                                                       : cfg.standstill_cmd;
      rsp_word.fan_active        = hold;
      rsp_word.spinup_done       = completed;
   end

endmodule
`default_nettype wire

// ===== rtl/core/fan_boost_activation_sequencer.sv =====
// Fan boost activation sequencer top level
// An accepted input word is held in the input register and its result word in the
// result register, which drives rsp. Throughput: one word per cycle unless rsp
// stalls; the tick state loop closes through the step logic between the two registers.
// Reset: clears the valid bits of both pipeline registers and the tick state but sets
// fan_permit, and loads the configuration registers with their default values.
`default_nettype none
module fan_boost_activation_sequencer (
   input  wire                                     clock,
   input  wire                                     reset,
   fbas_chan_if.sink                               req,
   fbas_chan_if.source                             rsp,
   input  wire                                     csr_we,
   input  wire  [fbas_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  wire  [fbas_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import fbas_pkg::*;
   `include "assert_macros.svh"

   fbas_cfg_type   cfg_ff;
   fbas_cfg_type   cfg_in;
   fbas_state_type state_ff;
   fbas_state_type state_in;
   fbas_req_type   s1_data_ff;
   logic           s1_valid_ff;
   fbas_rsp_type   out_data_ff;
   fbas_rsp_type   out_data_in;
   logic           out_valid_ff;
   logic           advance;

   assign advance   = !out_valid_ff || rsp.ready;
   assign req.ready = !s1_valid_ff || advance;
   assign rsp.valid = out_valid_ff;
   assign rsp.data  = out_data_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SPINUP_COUNTDOWN: cfg_in.spinup_countdown_ms  = csr_wdata[12:0];
            CSR_ACTIVE_HOLD:      cfg_in.active_hold_ms       = csr_wdata[12:0];
            CSR_MIN_SPEED:        cfg_in.min_speed_mm_s       = csr_wdata[14:0];
            CSR_STOP_DISTANCE:    cfg_in.stop_distance_mm     = csr_wdata[15:0];
            CSR_STEER_THRESHOLD:  cfg_in.steer_threshold_mrad = csr_wdata[11:0];
            CSR_STANDSTILL:       cfg_in.standstill_cmd       = csr_wdata[7:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.spinup_countdown_ms  <= RESET_SPINUP_COUNTDOWN;
         cfg_ff.active_hold_ms       <= RESET_ACTIVE_HOLD;
         cfg_ff.min_speed_mm_s       <= RESET_MIN_SPEED;
         cfg_ff.stop_distance_mm     <= RESET_STOP_DISTANCE;
         cfg_ff.steer_threshold_mrad <= RESET_STEER_THRESHOLD;
         cfg_ff.standstill_cmd       <= RESET_STANDSTILL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fbas_step u_step (
      .cfg      (cfg_ff),
      .state    (state_ff),
      .req_word (s1_data_ff),
      .state_in (state_in),
      .rsp_word (out_data_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req.ready) begin
            s1_valid_ff <= req.valid;
         end
         if (advance) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         s1_data_ff <= req.data;
      end
      if (advance && s1_valid_ff) begin
         out_data_ff <= out_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.sequence_started <= 1'b0;
         state_ff.spinup_completed <= 1'b0;
         state_ff.fan_permit       <= 1'b1;
         state_ff.hold_active      <= 1'b0;
         state_ff.spinup_timer_ms  <= '0;
         state_ff.hold_timer_ms    <= '0;
      end else if (advance && s1_valid_ff) begin
         state_ff <= state_in;
      end
   end

   `FBAS_ASSERT(a_hold_needs_sequence, clock, reset,
      !state_ff.hold_active || state_ff.sequence_started)
   `FBAS_ASSERT(a_done_needs_sequence, clock, reset,
      !state_ff.spinup_completed || state_ff.sequence_started)
   `FBAS_ASSERT(a_spinup_floor, clock, reset,
      $signed(state_ff.spinup_timer_ms) >= $signed(TIMER_FLOOR_MS))
   `FBAS_ASSERT(a_hold_floor, clock, reset,
      $signed(state_ff.hold_timer_ms) >= $signed(TIMER_FLOOR_MS))
   `FBAS_ASSERT_NEXT(a_state_idle_hold, clock, reset,
      !s1_valid_ff, $stable(state_ff))

endmodule
`default_nettype wire
